// File: hdl/mfh_pkg.sv
// Package for the mode filter histogram core.
// Field widths, count limit and the control struct shared by the cell row.
// No dependencies.
package mfh_pkg;

  localparam int SAMPLE_W = 10;
  localparam int COUNT_W  = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic insert;
    logic hit_any;
    logic shift;
  } cell_ctl_t;

endpackage

// File: hdl/mfh_cell.sv
// One table entry of the mode filter: value, count and valid bit.
// Matches the broadcast sample, fills in order, shifts toward the head on query.
// Depends on mfh_pkg.
module mfh_cell import mfh_pkg::*; #(
  parameter int VAL_W = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  logic [VAL_W-1:0]   sample,
  input  logic               prev_valid,
  input  logic               nb_valid,
  input  logic [VAL_W-1:0]   nb_value,
  input  logic [COUNT_W-1:0] nb_count,
  output logic               valid,
  output logic [VAL_W-1:0]   value,
  output logic [COUNT_W-1:0] count,
  output logic               match
);

  logic               valid_r, valid_nxt;
  logic [VAL_W-1:0]   value_r, value_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               take;

  assign match = valid_r && (value_r == sample);
  assign take  = ctl.insert && !ctl.hit_any && !valid_r && prev_valid;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    count_nxt = count_r;
    if (ctl.shift) begin
      valid_nxt = nb_valid;
      value_nxt = nb_value;
      count_nxt = nb_count;
    end else if (ctl.insert) begin
      if (match && count_r != COUNT_MAX) begin
        count_nxt = count_r + COUNT_W'(1);
      end else if (take) begin
        valid_nxt = 1'b1;
        value_nxt = sample;
        count_nxt = COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
    count_r <= count_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;
  assign count = count_r;

endmodule

// File: hdl/mfh_pick.sv
// Running maximum at the head of the cell row; later entries win ties.
// Depends on mfh_pkg.
module mfh_pick import mfh_pkg::*; #(
  parameter int VAL_W = 10
) (
  input  logic               clk,
  input  logic               start,
  input  logic               step,
  input  logic               head_valid,
  input  logic [VAL_W-1:0]   head_value,
  input  logic [COUNT_W-1:0] head_count,
  output logic [VAL_W-1:0]   best_value
);

  logic [VAL_W-1:0]   best_val_r, best_val_nxt;
  logic [COUNT_W-1:0] best_cnt_r, best_cnt_nxt;

  always_comb begin
    best_val_nxt = best_val_r;
    best_cnt_nxt = best_cnt_r;
    if (start) begin
      best_val_nxt = '0;
      best_cnt_nxt = '0;
    end else if (step && head_valid && head_count >= best_cnt_r) begin
      best_val_nxt = head_value;
      best_cnt_nxt = head_count;
    end
  end

  always_ff @(posedge clk) begin
    best_val_r <= best_val_nxt;
    best_cnt_r <= best_cnt_nxt;
  end

  assign best_value = best_val_r;

endmodule

// File: hdl/mode_filter_histogram_core.sv
// Top level of the mode filter histogram core: cell row, head picker, control.
// Depends on mfh_pkg, mfh_cell, mfh_pick.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_command, in_sample
//   out     | output    | out_valid, out_ready, out_mode_value, out_no_samples, out_overflowed
//
// Insert: one item per cycle while in_ready is high, all cells compare the sample at once.
// Query: shifts the whole row through the head picker, which also empties
// the table, then loads the result register.
// in_ready is low while a query runs; inserts are taken while a result waits.
// A query whose result register is still full waits before loading it.
// Reset (rst_n low, synchronous) empties the table and the drop flag.
module mode_filter_histogram_core import mfh_pkg::*; #(
  parameter int TABLE_SIZE  = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_mode_value,
  output logic                out_no_samples,
  output logic                out_overflowed
);

  localparam int VAL_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CNT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TABLE_SIZE - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             drop_r, drop_nxt;
  logic             empty_snap_r, empty_snap_nxt;
  logic             ovf_snap_r, ovf_snap_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             accept, do_insert, do_query, load_out;
  logic [VAL_W-1:0] sample_v;
  logic [VAL_W-1:0] best_value;
  cell_ctl_t        ctl;

  logic               valid_w [TABLE_SIZE+1];
  logic [VAL_W-1:0]   value_w [TABLE_SIZE+1];
  logic [COUNT_W-1:0] count_w [TABLE_SIZE+1];
  logic [TABLE_SIZE-1:0] match_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign do_insert = accept && (in_command == CMD_INSERT);
  assign do_query  = accept && (in_command == CMD_QUERY);
  assign sample_v  = in_sample[VAL_W-1:0];

  assign ctl.insert  = do_insert;
  assign ctl.hit_any = |match_w;
  assign ctl.shift   = (state_r == ST_SCAN);

  assign valid_w[TABLE_SIZE] = 1'b0;
  assign value_w[TABLE_SIZE] = '0;
  assign count_w[TABLE_SIZE] = '0;

  genvar g;
  generate
    for (g = 0; g < TABLE_SIZE; g++) begin : g_cell
      logic prev_v;
      if (g == 0) begin : g_head
        assign prev_v = 1'b1;
      end else begin : g_body
        assign prev_v = valid_w[g-1];
      end
      mfh_cell #(.VAL_W(VAL_W)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sample     (sample_v),
        .prev_valid (prev_v),
        .nb_valid   (valid_w[g+1]),
        .nb_value   (value_w[g+1]),
        .nb_count   (count_w[g+1]),
        .valid      (valid_w[g]),
        .value      (value_w[g]),
        .count      (count_w[g]),
        .match      (match_w[g])
      );
    end
  endgenerate

  mfh_pick #(.VAL_W(VAL_W)) u_pick (
    .clk        (clk),
    .start      (do_query),
    .step       (state_r == ST_SCAN),
    .head_valid (valid_w[0]),
    .head_value (value_w[0]),
    .head_count (count_w[0]),
    .best_value (best_value)
  );

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    drop_nxt       = drop_r;
    empty_snap_nxt = empty_snap_r;
    ovf_snap_nxt   = ovf_snap_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_empty_nxt  = out_empty_r;
    out_ovf_nxt    = out_ovf_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (do_insert && !ctl.hit_any && valid_w[TABLE_SIZE-1]) begin
          drop_nxt = 1'b1;
        end
        if (do_query) begin
          empty_snap_nxt = !valid_w[0];
          ovf_snap_nxt   = drop_r;
          drop_nxt       = 1'b0;
          step_nxt       = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        step_nxt = step_r + CNT_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = best_value;
          out_empty_nxt = empty_snap_r;
          out_ovf_nxt   = ovf_snap_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r       <= step_nxt;
    empty_snap_r <= empty_snap_nxt;
    ovf_snap_r   <= ovf_snap_nxt;
    out_value_r  <= out_value_nxt;
    out_empty_r  <= out_empty_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_mode_value = SAMPLE_W'(out_value_r);
  assign out_no_samples = out_empty_r;
  assign out_overflowed = out_ovf_r;

endmodule
